FILE: hdl/mfde_pkg.sv
package mfde_pkg;

	localparam int SCREEN_WIDTH_DEF  = 128;
	localparam int SCREEN_HEIGHT_DEF = 64;
	localparam logic [7:0] FONT_FIRST   = 8'h20;
	localparam logic [7:0] FONT_ROWS    = 8'd59;
	localparam logic [7:0] GLYPH_W      = 8'd6;
	localparam logic [7:0] GLYPH_H      = 8'd8;
	localparam logic [7:0] LINE_ADVANCE = 8'd10;

	// request codes
	localparam logic [2:0] REQ_PIXEL = 3'd0;
	localparam logic [2:0] REQ_LINE  = 3'd1;
	localparam logic [2:0] REQ_BAR   = 3'd2;
	localparam logic [2:0] REQ_GLYPH = 3'd3;
	localparam logic [2:0] REQ_CLEAR = 3'd4;
	localparam logic [2:0] REQ_READ  = 3'd5;

	// register indexes
	localparam logic [0:0] REG_DISPLAY_PRESENT = 1'b0;

	// font rom: one column byte of one glyph
	function automatic logic [7:0] glyph_col(input logic [5:0] row, input logic [2:0] col);
		logic [47:0] g;
		case (row)
			6'd0:  g = 48'h000000000000;
			6'd1:  g = 48'h00005F000000;
			6'd2:  g = 48'h000700070000;
			6'd3:  g = 48'h147F147F1400;
			6'd4:  g = 48'h242A7F2A1200;
			6'd5:  g = 48'h231308646200;
			6'd6:  g = 48'h364955225000;
			6'd7:  g = 48'h000503000000;
			6'd8:  g = 48'h001C22410000;
			6'd9:  g = 48'h0041221C0000;
			6'd10: g = 48'h082A1C2A0800;
			6'd11: g = 48'h08083E080800;
			6'd12: g = 48'h005030000000;
			6'd13: g = 48'h080808080800;
			6'd14: g = 48'h006060000000;
			6'd15: g = 48'h201008040200;
			6'd16: g = 48'h3E5149453E00;
			6'd17: g = 48'h00427F400000;
			6'd18: g = 48'h426151494600;
			6'd19: g = 48'h2141454B3100;
			6'd20: g = 48'h1814127F1000;
			6'd21: g = 48'h274545453900;
			6'd22: g = 48'h3C4A49493000;
			6'd23: g = 48'h017109050300;
			6'd24: g = 48'h364949493600;
			6'd25: g = 48'h064949291E00;
			6'd26: g = 48'h003636000000;
			6'd27: g = 48'h005636000000;
			6'd28: g = 48'h000814224100;
			6'd29: g = 48'h141414141400;
			6'd30: g = 48'h412214080000;
			6'd31: g = 48'h020151090600;
			6'd32: g = 48'h324979413E00;
			6'd33: g = 48'h7E1111117E00;
			6'd34: g = 48'h7F4949493600;
			6'd35: g = 48'h3E4141412200;
			6'd36: g = 48'h7F4141221C00;
			6'd37: g = 48'h7F4949494100;
			6'd38: g = 48'h7F0909010100;
			6'd39: g = 48'h3E4141513200;
			6'd40: g = 48'h7F0808087F00;
			6'd41: g = 48'h00417F410000;
			6'd42: g = 48'h2040413F0100;
			6'd43: g = 48'h7F0814224100;
			6'd44: g = 48'h7F4040404000;
			6'd45: g = 48'h7F0204027F00;
			6'd46: g = 48'h7F0408107F00;
			6'd47: g = 48'h3E4141413E00;
			6'd48: g = 48'h7F0909090600;
			6'd49: g = 48'h3E4151215E00;
			6'd50: g = 48'h7F0919294600;
			6'd51: g = 48'h464949493100;
			6'd52: g = 48'h01017F010100;
			6'd53: g = 48'h3F4040403F00;
			6'd54: g = 48'h1F2040201F00;
			6'd55: g = 48'h7F2018207F00;
			6'd56: g = 48'h631408146300;
			6'd57: g = 48'h030478040300;
			6'd58: g = 48'h615149454300;
			default: g = 48'h000000000000;
		endcase
		case (col)
			3'd0: glyph_col = g[47:40];
			3'd1: glyph_col = g[39:32];
			3'd2: glyph_col = g[31:24];
			3'd3: glyph_col = g[23:16];
			3'd4: glyph_col = g[15:8];
			3'd5: glyph_col = g[7:0];
			default: glyph_col = 8'h00;
		endcase
	endfunction

endpackage

FILE: hdl/mono_framebuffer_draw_engine.sv
// Monochrome 1 bpp frame store with a pixel, line, bar and glyph engine.
// Command channel: a request transfers at a rising edge with start high
// and busy low. Every request gives exactly one result: done pulses high
// for one cycle with read_byte, next_x and next_y; the receiver cannot
// stall, so the result is simply taken at the end of that cycle.
// Each plotted pixel is a read-modify-write of one store byte through the
// single store port, in the steps address, read, write back and step.
// A pixel plots one point, a line every point from start to end, a bar
// w*min(h,height) pixels, a glyph 6x8 pixels (none without panel), a
// read fetches one byte and a clear writes every store byte; empty bars
// and unused codes plot nothing. The next request can transfer at the
// edge that takes the result.
// The line stepper, bar and glyph counters share one plot sequencer.
// After reset the store is swept to zero, one byte per cycle, over all
// SCREEN_WIDTH*ceil(SCREEN_HEIGHT/8) bytes; busy is high meanwhile.
// display_present is register 0 on the APB port (address 0); glyph
// requests draw nothing while it is zero.
module mono_framebuffer_draw_engine #(
	parameter int SCREEN_WIDTH  = mfde_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = mfde_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  req_type,
	input  logic [7:0]  x_start,
	input  logic [7:0]  y_start,
	input  logic [7:0]  x_end,
	input  logic [7:0]  y_end,
	input  logic [7:0]  bar_width,
	input  logic [7:0]  bar_height,
	input  logic        pixel_on,
	input  logic [7:0]  char_code,
	input  logic [9:0]  read_index,
	output logic        done,
	output logic [7:0]  read_byte,
	output logic [7:0]  next_x,
	output logic [7:0]  next_y,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int PAGES = (SCREEN_HEIGHT + 7) / 8;
	localparam int STORE = SCREEN_WIDTH * PAGES;
	localparam int AW    = (STORE > 1) ? $clog2(STORE) : 1;

	typedef enum logic [3:0] {
		ST_SWEEP, ST_IDLE, ST_PLOT_A, ST_PLOT_R, ST_PLOT_W, ST_NEXT,
		ST_RD_A, ST_RD_W, ST_RD_D, ST_DONE
	} state_t;

	state_t      state_q;
	logic [7:0]  mem [STORE];
	logic [7:0]  rdata_q;
	logic [AW:0] sweep_q;
	logic [2:0]  req_q;
	logic [7:0]  px_q, py_q, xs_q, ys_q, xe_q, ye_q, bw_q, bh_q;
	logic [7:0]  i_q, j_q;
	logic        on_q;
	logic [5:0]  grow_q;
	logic signed [9:0] dx_q, dy_q, err_q;
	logic        sxn_q, syn_q;
	logic [AW-1:0] addr_q;
	logic        hit_q;
	logic [7:0]  mask_q;
	logic        disp_q;
	logic [7:0]  rb_q, nx_q, ny_q;
	logic        done_q;
	logic        we;
	logic [7:0]  wdata;
	logic [9:0]  read_index_q;
	logic        rd_wait_q;

	// config port
	assign pready = 1'b1;
	assign prdata = {31'd0, disp_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disp_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr == {mfde_pkg::REG_DISPLAY_PRESENT, 1'b0})
		begin
			disp_q <= pwdata[0];
		end
	end

	// pixel address and clip
	logic [AW+8:0] paddr_full;
	logic          pin;
	assign pin = (32'(px_q) < SCREEN_WIDTH) && (32'(py_q) < SCREEN_HEIGHT);
	assign paddr_full = (AW+9)'(py_q >> 3) * (AW+9)'(SCREEN_WIDTH) + (AW+9)'(px_q);

	// bresenham step terms
	logic signed [10:0] e2;
	assign e2 = {err_q, 1'b0};

	// glyph column for the current cell
	logic [7:0] gcol;
	assign gcol = mfde_pkg::glyph_col(grow_q, i_q[2:0]);

	// store port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr_q] <= wdata;
		end
		rdata_q <= mem[addr_q];
	end

	always_comb begin
		we = 1'b0;
		wdata = 8'h00;
		if (state_q == ST_SWEEP || (state_q == ST_NEXT && req_q == mfde_pkg::REQ_CLEAR)) begin
			we = 1'b1;
		end else if (state_q == ST_PLOT_W && hit_q) begin
			we = 1'b1;
			wdata = on_q ? (rdata_q | mask_q) : (rdata_q & ~mask_q);
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign read_byte = rb_q;
	assign next_x = nx_q;
	assign next_y = ny_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
			sweep_q <= '0;
			addr_q  <= '0;
			done_q  <= 1'b0;
			req_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_SWEEP: begin
					if (sweep_q == (AW+1)'(STORE - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						sweep_q <= sweep_q + 1'b1;
						addr_q  <= AW'(sweep_q + 1'b1);
					end
				end
				ST_IDLE: begin
					if (start) begin
						req_q <= req_type;
						xs_q <= x_start; ys_q <= y_start;
						xe_q <= x_end;   ye_q <= y_end;
						bw_q <= bar_width;
						bh_q <= (32'(bar_height) > SCREEN_HEIGHT) ? 8'(SCREEN_HEIGHT)
							: bar_height;
						on_q <= pixel_on;
						i_q <= '0; j_q <= '0;
						rb_q <= '0; nx_q <= '0; ny_q <= '0;
						grow_q <= ((char_code - mfde_pkg::FONT_FIRST) < mfde_pkg::FONT_ROWS)
							? 6'(char_code - mfde_pkg::FONT_FIRST) : 6'd0;
						dx_q <= (x_end > x_start) ? 10'(x_end - x_start) : 10'(x_start - x_end);
						dy_q <= (y_end > y_start) ? 10'(y_end - y_start) : 10'(y_start - y_end);
						err_q <= ((x_end > x_start) ? 10'(x_end - x_start) : 10'(x_start - x_end))
							- ((y_end > y_start) ? 10'(y_end - y_start) : 10'(y_start - y_end));
						sxn_q <= !(x_start < x_end);
						syn_q <= !(y_start < y_end);
						px_q <= x_start; py_q <= y_start;
						case (req_type)
							mfde_pkg::REQ_PIXEL, mfde_pkg::REQ_LINE: state_q <= ST_PLOT_A;
							mfde_pkg::REQ_BAR: begin
								px_q <= x_start;
								py_q <= 8'(SCREEN_HEIGHT - 1);
								if (bar_width == 8'd0 || bar_height == 8'd0)
									state_q <= ST_DONE;
								else
									state_q <= ST_PLOT_A;
							end
							mfde_pkg::REQ_GLYPH: begin
								nx_q <= x_start; ny_q <= y_start;
								state_q <= disp_q ? ST_PLOT_A : ST_DONE;
							end
							mfde_pkg::REQ_CLEAR: begin
								addr_q <= '0; sweep_q <= '0;
								state_q <= ST_NEXT;
							end
							mfde_pkg::REQ_READ: state_q <= ST_RD_A;
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_PLOT_A: begin
					addr_q <= AW'(paddr_full);
					hit_q  <= pin && (paddr_full < (AW+9)'(STORE));
					mask_q <= 8'(1) << py_q[2:0];
					if (req_q == mfde_pkg::REQ_LINE || req_q == mfde_pkg::REQ_BAR)
						on_q <= 1'b1;
					else if (req_q == mfde_pkg::REQ_GLYPH)
						on_q <= gcol[j_q[2:0]];
					state_q <= ST_PLOT_R;
				end
				ST_PLOT_R: state_q <= ST_PLOT_W;
				ST_PLOT_W: state_q <= ST_NEXT;
				ST_NEXT: begin
					state_q <= ST_PLOT_A;
					case (req_q)
						mfde_pkg::REQ_PIXEL: state_q <= ST_DONE;
						mfde_pkg::REQ_LINE: begin
							if (px_q == xe_q && py_q == ye_q) begin
								state_q <= ST_DONE;
							end else begin
								if (e2 > -11'(dy_q)) begin
									px_q <= sxn_q ? px_q - 1'b1 : px_q + 1'b1;
								end
								if (e2 < 11'(dx_q)) begin
									py_q <= syn_q ? py_q - 1'b1 : py_q + 1'b1;
								end
								err_q <= err_q - ((e2 > -11'(dy_q)) ? dy_q : 10'sd0)
									+ ((e2 < 11'(dx_q)) ? dx_q : 10'sd0);
							end
						end
						mfde_pkg::REQ_BAR: begin
							if (j_q + 1'b1 == bh_q) begin
								j_q <= '0;
								py_q <= 8'(SCREEN_HEIGHT - 1);
								i_q <= i_q + 1'b1;
								px_q <= xs_q + i_q + 1'b1;
								if (i_q + 1'b1 == bw_q) state_q <= ST_DONE;
							end else begin
								j_q <= j_q + 1'b1;
								py_q <= py_q - 1'b1;
							end
						end
						mfde_pkg::REQ_GLYPH: begin
							if (j_q == mfde_pkg::GLYPH_H - 1'b1) begin
								j_q <= '0;
								py_q <= ys_q;
								i_q <= i_q + 1'b1;
								px_q <= xs_q + i_q + 1'b1;
								if (i_q == mfde_pkg::GLYPH_W - 1'b1) begin
									state_q <= ST_DONE;
									if (32'(8'(xs_q + mfde_pkg::GLYPH_W)) >
										SCREEN_WIDTH - 32'(mfde_pkg::GLYPH_W)) begin
										nx_q <= 8'd0;
										ny_q <= ys_q + mfde_pkg::LINE_ADVANCE;
									end else begin
										nx_q <= xs_q + mfde_pkg::GLYPH_W;
									end
								end
							end else begin
								j_q <= j_q + 1'b1;
								py_q <= py_q + 1'b1;
							end
						end
						mfde_pkg::REQ_CLEAR: begin
							state_q <= ST_NEXT;
							if (sweep_q == (AW+1)'(STORE - 1)) begin
								state_q <= ST_DONE;
							end else begin
								sweep_q <= sweep_q + 1'b1;
								addr_q <= AW'(sweep_q + 1'b1);
							end
						end
						default: state_q <= ST_DONE;
					endcase
				end
				ST_RD_A: begin
					addr_q <= AW'(read_index_q);
					state_q <= ST_RD_W;
				end
				ST_RD_W: state_q <= ST_RD_D;
				ST_RD_D: begin
					if (32'(read_index_q) < STORE) rb_q <= rdata_q;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					done_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// read index hold; the read data is registered behind the address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_wait_q <= 1'b0;
		end else begin
			rd_wait_q <= (state_q == ST_RD_W);
		end
	end
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) read_index_q <= read_index;
	end

	// checks
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("not busy after start");
	a_rd_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD_D) |-> rd_wait_q) else $error("read data early");

endmodule
